/* rtl/dsdop_pkg.sv */
package dsdop_pkg;

  typedef enum logic [3:0] {
    PH_ID    = 4'd0,
    PH_SIZE  = 4'd1,
    PH_FORM  = 4'd2,
    PH_FVER  = 4'd3,
    PH_PROP  = 4'd4,
    PH_FS    = 4'd5,
    PH_CHNL  = 4'd6,
    PH_CMPR  = 4'd7,
    PH_SOUND = 4'd8,
    PH_SKIP  = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    ERR_NONE        = 5'd0,
    ERR_TRUNC       = 5'd1,
    ERR_FRM8_SIZE   = 5'd2,
    ERR_FRM8_FORM   = 5'd3,
    ERR_FVER_SIZE   = 5'd4,
    ERR_FVER_VER    = 5'd5,
    ERR_PROP_SIZE   = 5'd6,
    ERR_PROP_TYPE   = 5'd7,
    ERR_FS_SIZE     = 5'd8,
    ERR_FS_RATE     = 5'd9,
    ERR_CHNL_SIZE   = 5'd10,
    ERR_CHNL_COUNT  = 5'd11,
    ERR_CMPR_SIZE   = 5'd12,
    ERR_CMPR_TYPE   = 5'd13,
    ERR_DSD_SIZE    = 5'd14,
    ERR_CHUNK_SIZE  = 5'd15,
    ERR_MISSING     = 5'd16,
    ERR_FMT_NONE    = 5'd17
  } err_t;

  localparam logic [1:0] FMT_NONE  = 2'd0;
  localparam logic [1:0] FMT_DOP24 = 2'd1;
  localparam logic [1:0] FMT_RESET = 2'd2;

  localparam logic [1:0] CFG_OUT_FORMAT    = 2'd0;
  localparam logic [1:0] CFG_REQUIRED_RATE = 2'd1;

  localparam logic [31:0] RATE_RESET = 32'd2822400;

  localparam logic [31:0] ID_FRM8  = 32'h384d5246;
  localparam logic [31:0] ID_FVER  = 32'h52455646;
  localparam logic [31:0] ID_PROP  = 32'h504f5250;
  localparam logic [31:0] ID_FS    = 32'h20205346;
  localparam logic [31:0] ID_CHNL  = 32'h4c4e4843;
  localparam logic [31:0] ID_CMPR  = 32'h52504d43;
  localparam logic [31:0] ID_DSD   = 32'h20445344;
  localparam logic [31:0] TYPE_SND = 32'h20444e53;
  localparam logic [7:0]  VER_ONE  = 8'h01;
  localparam logic [7:0]  MARK_A   = 8'h05;
  localparam logic [7:0]  MARK_B   = 8'hfa;
  localparam logic [6:0]  SEEN_ALL = 7'h7f;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic        ch;
    logic [4:0]  err;
    logic        last;
  } rec_t;

endpackage

/* rtl/dsdop_parser.sv */
module dsdop_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                mode,
  input  logic [7:0]          data_byte,
  input  logic [1:0]          out_format,
  input  logic [31:0]         required_rate,
  output logic [1:0]          res_cnt,
  output dsdop_pkg::rec_t     res0,
  output dsdop_pkg::rec_t     res1
);

  dsdop_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  fbc_r, fbc_nxt;
  logic [63:0] size_r, size_nxt;
  logic [31:0] ws_r, ws_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic        pad_r, pad_nxt;
  logic [6:0]  seen_r, seen_nxt;
  logic [7:0]  held_r [3];
  logic [7:0]  held_nxt [3];
  logic [1:0]  gpos_r, gpos_nxt;
  logic        par_r, par_nxt;
  logic [4:0]  sticky_r, sticky_nxt;

  logic [63:0] rem_dec;
  logic [63:0] sz_next;
  logic        szn_bad, sz_big;
  logic [31:0] w_rev, w_fwd, w_chn;
  logic [4:0]  err;
  logic [7:0]  mark;
  logic [1:0]  n;
  dsdop_pkg::rec_t r0, r1;

  assign rem_dec = rem_r - 64'd1;
  assign sz_next = {size_r[55:0], data_byte};
  assign szn_bad = (sz_next == 64'd0) || (|sz_next[63:31]);
  assign sz_big  = |size_r[63:31];
  assign w_rev   = {data_byte, ws_r[31:8]};
  assign w_fwd   = {ws_r[23:0], data_byte};
  assign w_chn   = {16'd0, ws_r[7:0], data_byte};
  assign mark    = par_r ? dsdop_pkg::MARK_B : dsdop_pkg::MARK_A;

  always_comb begin
    phase_nxt  = phase_r;
    fbc_nxt    = fbc_r;
    size_nxt   = size_r;
    ws_nxt     = ws_r;
    rem_nxt    = rem_r;
    pad_nxt    = pad_r;
    seen_nxt   = seen_r;
    held_nxt   = held_r;
    gpos_nxt   = gpos_r;
    par_nxt    = par_r;
    sticky_nxt = sticky_r;
    err        = dsdop_pkg::ERR_NONE;
    n          = 2'd0;
    r0         = '0;
    r1         = '0;
    if (fire) begin
      if (mode) begin
        r0.kind = dsdop_pkg::KIND_STATUS;
        r0.last = 1'b1;
        if (sticky_r != 5'd0) r0.err = sticky_r;
        else if (out_format == dsdop_pkg::FMT_NONE) r0.err = dsdop_pkg::ERR_FMT_NONE;
        else if (phase_r != dsdop_pkg::PH_ID && phase_r != dsdop_pkg::PH_SKIP)
          r0.err = dsdop_pkg::ERR_TRUNC;
        else if (seen_r != dsdop_pkg::SEEN_ALL) r0.err = dsdop_pkg::ERR_MISSING;
        else r0.err = dsdop_pkg::ERR_NONE;
        n = 2'd1;
        phase_nxt  = dsdop_pkg::PH_ID;
        fbc_nxt    = 3'd0;
        size_nxt   = 64'd0;
        ws_nxt     = 32'd0;
        rem_nxt    = 64'd0;
        pad_nxt    = 1'b0;
        seen_nxt   = 7'd0;
        gpos_nxt   = 2'd0;
        par_nxt    = 1'b0;
        sticky_nxt = 5'd0;
      end else if (sticky_r != 5'd0) begin
        n = 2'd0;
      end else if (out_format == dsdop_pkg::FMT_NONE) begin
        err = dsdop_pkg::ERR_FMT_NONE;
      end else begin
        case (phase_r)
          dsdop_pkg::PH_ID: begin
            ws_nxt  = w_rev;
            fbc_nxt = fbc_r + 3'd1;
            if (fbc_r == 3'd3) begin
              fbc_nxt   = 3'd0;
              size_nxt  = 64'd0;
              phase_nxt = dsdop_pkg::PH_SIZE;
            end
          end
          dsdop_pkg::PH_SIZE: begin
            size_nxt = sz_next;
            fbc_nxt  = fbc_r + 3'd1;
            if (fbc_r == 3'd7) begin
              fbc_nxt = 3'd0;
              case (ws_r)
                dsdop_pkg::ID_FRM8: begin phase_nxt = dsdop_pkg::PH_FORM; ws_nxt = '0; end
                dsdop_pkg::ID_FVER: begin phase_nxt = dsdop_pkg::PH_FVER; ws_nxt = '0; end
                dsdop_pkg::ID_PROP: begin phase_nxt = dsdop_pkg::PH_PROP; ws_nxt = '0; end
                dsdop_pkg::ID_FS:   begin phase_nxt = dsdop_pkg::PH_FS;   ws_nxt = '0; end
                dsdop_pkg::ID_CHNL: begin phase_nxt = dsdop_pkg::PH_CHNL; ws_nxt = '0; end
                dsdop_pkg::ID_CMPR: begin phase_nxt = dsdop_pkg::PH_CMPR; ws_nxt = '0; end
                dsdop_pkg::ID_DSD: begin
                  if (szn_bad) err = dsdop_pkg::ERR_DSD_SIZE;
                  else begin
                    seen_nxt[6] = 1'b1;
                    rem_nxt     = sz_next;
                    pad_nxt     = sz_next[0];
                    gpos_nxt    = 2'd0;
                    par_nxt     = 1'b0;
                    phase_nxt   = dsdop_pkg::PH_SOUND;
                  end
                end
                default: begin
                  if (szn_bad) err = dsdop_pkg::ERR_CHUNK_SIZE;
                  else begin
                    rem_nxt   = sz_next;
                    pad_nxt   = sz_next[0];
                    phase_nxt = dsdop_pkg::PH_SKIP;
                  end
                end
              endcase
            end
          end
          dsdop_pkg::PH_FORM, dsdop_pkg::PH_PROP, dsdop_pkg::PH_CMPR,
          dsdop_pkg::PH_FVER, dsdop_pkg::PH_FS: begin
            if (phase_r == dsdop_pkg::PH_FVER || phase_r == dsdop_pkg::PH_FS)
              ws_nxt = w_fwd;
            else
              ws_nxt = w_rev;
            fbc_nxt = fbc_r + 3'd1;
            if (fbc_r == 3'd3) begin
              phase_nxt = dsdop_pkg::PH_ID;
              fbc_nxt   = 3'd0;
              case (phase_r)
                dsdop_pkg::PH_FORM: begin
                  if (sz_big) err = dsdop_pkg::ERR_FRM8_SIZE;
                  else if (ws_nxt != dsdop_pkg::ID_DSD) err = dsdop_pkg::ERR_FRM8_FORM;
                  else seen_nxt[0] = (size_r != 64'd0);
                end
                dsdop_pkg::PH_FVER: begin
                  if (size_r != 64'd4) err = dsdop_pkg::ERR_FVER_SIZE;
                  else if (ws_nxt[31:24] != dsdop_pkg::VER_ONE) err = dsdop_pkg::ERR_FVER_VER;
                  else seen_nxt[1] = 1'b1;
                end
                dsdop_pkg::PH_PROP: begin
                  if (size_r < 64'd4) err = dsdop_pkg::ERR_PROP_SIZE;
                  else if (ws_nxt != dsdop_pkg::TYPE_SND) err = dsdop_pkg::ERR_PROP_TYPE;
                  else seen_nxt[2] = 1'b1;
                end
                dsdop_pkg::PH_FS: begin
                  if (size_r != 64'd4) err = dsdop_pkg::ERR_FS_SIZE;
                  else if (ws_nxt != required_rate) err = dsdop_pkg::ERR_FS_RATE;
                  else seen_nxt[3] = 1'b1;
                end
                default: begin
                  if (size_r < 64'd5) err = dsdop_pkg::ERR_CMPR_SIZE;
                  else if (ws_nxt != dsdop_pkg::ID_DSD) err = dsdop_pkg::ERR_CMPR_TYPE;
                  else begin
                    seen_nxt[5] = 1'b1;
                    rem_nxt     = size_r - 64'd4;
                    pad_nxt     = size_r[0];
                    phase_nxt   = dsdop_pkg::PH_SKIP;
                  end
                end
              endcase
            end
          end
          dsdop_pkg::PH_CHNL: begin
            ws_nxt  = w_chn;
            fbc_nxt = fbc_r + 3'd1;
            if (fbc_r == 3'd1) begin
              phase_nxt = dsdop_pkg::PH_ID;
              fbc_nxt   = 3'd0;
              if (size_r < 64'd6) err = dsdop_pkg::ERR_CHNL_SIZE;
              else if (w_chn != 32'd2) err = dsdop_pkg::ERR_CHNL_COUNT;
              else begin
                seen_nxt[4] = 1'b1;
                rem_nxt     = size_r - 64'd2;
                pad_nxt     = size_r[0];
                phase_nxt   = dsdop_pkg::PH_SKIP;
              end
            end
          end
          dsdop_pkg::PH_SOUND: begin
            if (gpos_r != 2'd3) begin
              held_nxt[gpos_r] = data_byte;
              gpos_nxt = gpos_r + 2'd1;
            end else begin
              r0.kind = dsdop_pkg::KIND_SAMPLE;
              r1.kind = dsdop_pkg::KIND_SAMPLE;
              if (out_format == dsdop_pkg::FMT_DOP24) begin
                r0.word = {8'd0, mark, held_r[0], held_r[2]};
                r1.word = {8'd0, mark, held_r[1], data_byte};
              end else begin
                r0.word = {mark, held_r[0], held_r[2], 8'd0};
                r1.word = {mark, held_r[1], data_byte, 8'd0};
              end
              r1.ch   = 1'b1;
              r1.last = 1'b1;
              n        = 2'd2;
              par_nxt  = ~par_r;
              gpos_nxt = 2'd0;
            end
            rem_nxt = rem_dec;
            if (rem_dec == 64'd0)
              phase_nxt = pad_r ? dsdop_pkg::PH_SKIP : dsdop_pkg::PH_ID;
          end
          default: begin
            if (rem_r != 64'd0) rem_nxt = rem_dec;
            else pad_nxt = 1'b0;
            if (rem_nxt == 64'd0 && !pad_nxt) phase_nxt = dsdop_pkg::PH_ID;
          end
        endcase
      end
      if (err != 5'd0) begin
        sticky_nxt = err;
        r0         = '0;
        r0.kind    = dsdop_pkg::KIND_ERROR;
        r0.err     = err;
        r0.last    = 1'b1;
        n          = 2'd1;
      end
    end
  end

  assign res_cnt = n;
  assign res0    = r0;
  assign res1    = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= dsdop_pkg::PH_ID;
      fbc_r    <= 3'd0;
      size_r   <= 64'd0;
      ws_r     <= 32'd0;
      rem_r    <= 64'd0;
      pad_r    <= 1'b0;
      seen_r   <= 7'd0;
      gpos_r   <= 2'd0;
      par_r    <= 1'b0;
      sticky_r <= 5'd0;
    end else begin
      phase_r  <= phase_nxt;
      fbc_r    <= fbc_nxt;
      size_r   <= size_nxt;
      ws_r     <= ws_nxt;
      rem_r    <= rem_nxt;
      pad_r    <= pad_nxt;
      seen_r   <= seen_nxt;
      gpos_r   <= gpos_nxt;
      par_r    <= par_nxt;
      sticky_r <= sticky_nxt;
    end
  end

  // held bytes are always written before they are read
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

`ifndef SYNTH
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !mode && sticky_r != 5'd0) |-> (res_cnt == 2'd0))
    else $error("result after sticky error");
  a_sticky_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (sticky_r != 5'd0 && !(fire && mode)) |=> (sticky_r == $past(sticky_r)))
    else $error("sticky error changed");
  a_pair_sound: assert property (@(posedge clk) disable iff (!rst_n)
    (res_cnt == 2'd2) |-> (phase_r == dsdop_pkg::PH_SOUND && gpos_r == 2'd3))
    else $error("sample pair outside sound data");
`endif

endmodule

/* rtl/dsdop_outq.sv */
module dsdop_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_cnt,
  input  dsdop_pkg::rec_t push0,
  input  dsdop_pkg::rec_t push1,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output dsdop_pkg::rec_t out_rec
);

  dsdop_pkg::rec_t mem_r [dsdop_pkg::QDEPTH];
  logic [dsdop_pkg::QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [dsdop_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic [dsdop_pkg::QAW-1:0] wp1;
  logic                      pop;

  assign wp1       = wp_r + dsdop_pkg::QAW'(1);
  assign out_valid = (cnt_r != '0);
  assign out_rec   = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  // two slots free so a sample pair always fits
  assign room      = (cnt_r <= (dsdop_pkg::QAW+1)'(dsdop_pkg::QDEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + dsdop_pkg::QAW'(push_cnt);
    rp_nxt  = rp_r + dsdop_pkg::QAW'(pop);
    cnt_nxt = cnt_r + (dsdop_pkg::QAW+1)'(push_cnt) - (dsdop_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wp_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wp1] <= push1;
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (dsdop_pkg::QAW+1)'(dsdop_pkg::QDEPTH))
    else $error("queue overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == 2'd0 && !pop) |=> (cnt_r == $past(cnt_r)))
    else $error("queue count drift");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> (cnt_r <= (dsdop_pkg::QAW+1)'(dsdop_pkg::QDEPTH) -
      (dsdop_pkg::QAW+1)'(push_cnt)))
    else $error("push without room");
`endif

endmodule

/* rtl/dsdiff_to_dop_converter.sv */
// An accepted beat's results are written into the result queue and shown on out_* from there.
// Throughput: one input beat per cycle while in_tready is high; a sample group yields two
// output beats, drained at one per cycle while out_tready is high from a four-entry result queue.
// in_tready drops while fewer than two queue slots are free.
// Reset (rst_n low, synchronous): parser back to chunk-ID search, queue empty,
// out_format = 2, required_rate = 2822400.
module dsdiff_to_dop_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] sample_word, [32] channel, [37:33] error_code
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [1:0]  fmt_r;
  logic [31:0] rate_r;
  logic        in_fire;
  logic [1:0]  res_cnt;
  dsdop_pkg::rec_t res0, res1, orec;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= dsdop_pkg::FMT_RESET;
      rate_r <= dsdop_pkg::RATE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == dsdop_pkg::CFG_OUT_FORMAT) fmt_r <= cfg_data[1:0];
      if (cfg_index == dsdop_pkg::CFG_REQUIRED_RATE) rate_r <= cfg_data;
    end
  end

  dsdop_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (in_fire),
    .mode          (in_tuser),
    .data_byte     (in_tdata),
    .out_format    (fmt_r),
    .required_rate (rate_r),
    .res_cnt       (res_cnt),
    .res0          (res0),
    .res1          (res1)
  );

  dsdop_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (orec)
  );

  assign out_tdata = {2'b00, orec.err, orec.ch, orec.word};
  assign out_tuser = orec.kind;
  assign out_tlast = orec.last;

endmodule

/* test/dsdop_checker.sv */
`timescale 1ns / 100ps

module dsdop_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          checked
);

  localparam logic [63:0] SIZE_MAX = 64'h7fffffff;

  // mirrored registers
  logic [1:0]  fmt;
  logic [31:0] rate;

  // parser mirror
  dsdop_pkg::phase_t ph;
  logic [3:0]  fcnt;
  logic [63:0] szacc;
  logic [31:0] wsh;
  logic [63:0] brem;
  logic        pad;
  logic [6:0]  seen;
  logic [7:0]  held [3];
  logic [1:0]  gpos;
  logic        par;
  logic [4:0]  sticky;

  dsdop_pkg::rec_t results_q [$];

  assign pending = results_q.size();

  function automatic dsdop_pkg::rec_t mk(dsdop_pkg::kind_t k, logic [31:0] w, logic c,
                                         logic [4:0] e, logic l);
    dsdop_pkg::rec_t r;
    r.kind = k;
    r.word = w;
    r.ch   = c;
    r.err  = e;
    r.last = l;
    return r;
  endfunction

  task automatic clear_parser();
    ph = dsdop_pkg::PH_ID; fcnt = '0; szacc = '0; wsh = '0; brem = '0; pad = 1'b0;
    seen = '0; gpos = '0; par = 1'b0; sticky = '0;
    for (int i = 0; i < 3; i++) held[i] = '0;
  endtask

  function automatic void start_skip(logic [63:0] n, logic p);
    brem = n;
    pad  = p;
    ph   = (n != 0 || p) ? dsdop_pkg::PH_SKIP : dsdop_pkg::PH_ID;
  endfunction

  function automatic void open_field(dsdop_pkg::phase_t p);
    ph = p; fcnt = '0; wsh = '0;
  endfunction

  // chunk header complete: route on the ID
  function automatic logic [4:0] route_chunk();
    case (wsh)
      dsdop_pkg::ID_FRM8: open_field(dsdop_pkg::PH_FORM);
      dsdop_pkg::ID_FVER: open_field(dsdop_pkg::PH_FVER);
      dsdop_pkg::ID_PROP: open_field(dsdop_pkg::PH_PROP);
      dsdop_pkg::ID_FS:   open_field(dsdop_pkg::PH_FS);
      dsdop_pkg::ID_CHNL: open_field(dsdop_pkg::PH_CHNL);
      dsdop_pkg::ID_CMPR: open_field(dsdop_pkg::PH_CMPR);
      dsdop_pkg::ID_DSD: begin
        if (szacc == 0 || szacc > SIZE_MAX) return dsdop_pkg::ERR_DSD_SIZE;
        seen[6] = 1'b1;
        brem = szacc;
        pad  = szacc[0];
        gpos = '0;
        par  = 1'b0;
        ph   = dsdop_pkg::PH_SOUND;
      end
      default: begin
        if (szacc == 0 || szacc > SIZE_MAX) return dsdop_pkg::ERR_CHUNK_SIZE;
        start_skip(szacc, szacc[0]);
      end
    endcase
    return dsdop_pkg::ERR_NONE;
  endfunction

  function automatic logic [4:0] close_field(dsdop_pkg::phase_t p);
    ph = dsdop_pkg::PH_ID;
    fcnt = '0;
    case (p)
      dsdop_pkg::PH_FORM: begin
        if (szacc > SIZE_MAX) return dsdop_pkg::ERR_FRM8_SIZE;
        if (wsh != dsdop_pkg::ID_DSD) return dsdop_pkg::ERR_FRM8_FORM;
        seen[0] = (szacc != 0);
      end
      dsdop_pkg::PH_FVER: begin
        if (szacc != 4) return dsdop_pkg::ERR_FVER_SIZE;
        if (wsh[31:24] != dsdop_pkg::VER_ONE) return dsdop_pkg::ERR_FVER_VER;
        seen[1] = 1'b1;
      end
      dsdop_pkg::PH_PROP: begin
        if (szacc < 4) return dsdop_pkg::ERR_PROP_SIZE;
        if (wsh != dsdop_pkg::TYPE_SND) return dsdop_pkg::ERR_PROP_TYPE;
        seen[2] = 1'b1;
      end
      dsdop_pkg::PH_FS: begin
        if (szacc != 4) return dsdop_pkg::ERR_FS_SIZE;
        if (wsh != rate) return dsdop_pkg::ERR_FS_RATE;
        seen[3] = 1'b1;
      end
      dsdop_pkg::PH_CHNL: begin
        if (szacc < 6) return dsdop_pkg::ERR_CHNL_SIZE;
        if (wsh != 32'd2) return dsdop_pkg::ERR_CHNL_COUNT;
        seen[4] = 1'b1;
        start_skip(szacc - 2, szacc[0]);
      end
      default: begin
        if (szacc < 5) return dsdop_pkg::ERR_CMPR_SIZE;
        if (wsh != dsdop_pkg::ID_DSD) return dsdop_pkg::ERR_CMPR_TYPE;
        seen[5] = 1'b1;
        start_skip(szacc - 4, szacc[0]);
      end
    endcase
    return dsdop_pkg::ERR_NONE;
  endfunction

  task automatic sound_in(logic [7:0] b);
    logic [7:0]  m;
    logic [31:0] lw, rw;
    if (gpos < 3) begin
      held[gpos] = b;
      gpos++;
    end else begin
      m = par ? dsdop_pkg::MARK_B : dsdop_pkg::MARK_A;
      if (fmt == dsdop_pkg::FMT_DOP24) begin
        lw = {8'h00, m, held[0], held[2]};
        rw = {8'h00, m, held[1], b};
      end else begin
        lw = {m, held[0], held[2], 8'h00};
        rw = {m, held[1], b, 8'h00};
      end
      results_q.push_back(mk(dsdop_pkg::KIND_SAMPLE, lw, 1'b0, dsdop_pkg::ERR_NONE, 1'b0));
      results_q.push_back(mk(dsdop_pkg::KIND_SAMPLE, rw, 1'b1, dsdop_pkg::ERR_NONE, 1'b1));
      par  = ~par;
      gpos = '0;
    end
    brem--;
    if (brem == 0) start_skip(64'd0, pad);
  endtask

  task automatic parse_beat(logic eof, logic [7:0] b);
    logic [4:0] err;
    logic [4:0] code;
    err = dsdop_pkg::ERR_NONE;
    if (eof) begin
      if (sticky != 0) code = sticky;
      else if (fmt == dsdop_pkg::FMT_NONE) code = dsdop_pkg::ERR_FMT_NONE;
      else if (ph >= dsdop_pkg::PH_SIZE && ph <= dsdop_pkg::PH_SOUND)
        code = dsdop_pkg::ERR_TRUNC;
      else if (seen != dsdop_pkg::SEEN_ALL) code = dsdop_pkg::ERR_MISSING;
      else code = dsdop_pkg::ERR_NONE;
      results_q.push_back(mk(dsdop_pkg::KIND_STATUS, '0, 1'b0, code, 1'b1));
      clear_parser();
      return;
    end
    if (sticky != 0) return;
    if (fmt == dsdop_pkg::FMT_NONE) begin
      sticky = dsdop_pkg::ERR_FMT_NONE;
      results_q.push_back(mk(dsdop_pkg::KIND_ERROR, '0, 1'b0, dsdop_pkg::ERR_FMT_NONE,
                             1'b1));
      return;
    end
    case (ph)
      dsdop_pkg::PH_ID: begin
        wsh = {b, wsh[31:8]};
        fcnt++;
        if (fcnt >= 4) begin
          fcnt = '0; szacc = '0; ph = dsdop_pkg::PH_SIZE;
        end
      end
      dsdop_pkg::PH_SIZE: begin
        szacc = {szacc[55:0], b};
        fcnt++;
        if (fcnt >= 8) begin
          fcnt = '0;
          err = route_chunk();
        end
      end
      dsdop_pkg::PH_FORM, dsdop_pkg::PH_PROP, dsdop_pkg::PH_CMPR: begin
        wsh = {b, wsh[31:8]};
        fcnt++;
        if (fcnt >= 4) err = close_field(ph);
      end
      dsdop_pkg::PH_FVER, dsdop_pkg::PH_FS: begin
        wsh = {wsh[23:0], b};
        fcnt++;
        if (fcnt >= 4) err = close_field(ph);
      end
      dsdop_pkg::PH_CHNL: begin
        wsh = {16'h0000, wsh[7:0], b};
        fcnt++;
        if (fcnt >= 2) err = close_field(ph);
      end
      dsdop_pkg::PH_SOUND: sound_in(b);
      default: begin
        if (brem != 0) brem--;
        else pad = 1'b0;
        if (brem == 0 && !pad) ph = dsdop_pkg::PH_ID;
      end
    endcase
    if (err != 0) begin
      sticky = err;
      results_q.push_back(mk(dsdop_pkg::KIND_ERROR, '0, 1'b0, err, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    dsdop_pkg::rec_t want, got;
    if (!rst_n) begin
      fmt  = dsdop_pkg::FMT_RESET;
      rate = dsdop_pkg::RATE_RESET;
      clear_parser();
      results_q.delete();
      fails   <= 0;
      checked <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = mk(dsdop_pkg::kind_t'(out_tuser), out_tdata[31:0], out_tdata[32],
                 out_tdata[37:33], out_tlast);
        checked <= checked + 1;
        if (results_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
          fails <= fails + 1;
        end else begin
          want = results_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected kind %0d word %h ch %0d err %0d last %0d",
                     $time, want.kind, want.word, want.ch, want.err, want.last);
            $display("%0t:                    actual kind %0d word %h ch %0d err %0d last %0d",
                     $time, got.kind, got.word, got.ch, got.err, got.last);
            fails <= fails + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dsdop_pkg::CFG_OUT_FORMAT) fmt = cfg_data[1:0];
        else if (cfg_index == dsdop_pkg::CFG_REQUIRED_RATE) rate = cfg_data;
      end
      if (in_tvalid && in_tready) parse_beat(in_tuser, in_tdata);
    end
  end

endmodule

/* test/dsdiff_to_dop_converter_tb.sv */
`timescale 1ns / 100ps

module dsdiff_to_dop_converter_tb;

  localparam int STALL_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int fails, pending, checked;
  int tx_idle_pct, rx_idle_pct;
  int beats_sent, files_sent, quiet_cycles;
  logic [31:0] cur_rate;
  logic [7:0]  file_q [$];

  dsdiff_to_dop_converter dut (.*);

  dsdop_checker checker_i (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_beat(logic eof, logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= eof;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == dsdop_pkg::CFG_REQUIRED_RATE) cur_rate = val;
  endtask

  // IDs go out lowest byte first, sizes and numeric fields big-endian
  task automatic put_id(logic [31:0] id);
    for (int i = 0; i < 4; i++) file_q.push_back(id[8*i +: 8]);
  endtask

  task automatic put_be(logic [63:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) file_q.push_back(v[8*i +: 8]);
  endtask

  task automatic put_fill(int n, bit odd_pad);
    for (int i = 0; i < n; i++) file_q.push_back(8'($urandom));
    if (odd_pad) file_q.push_back(8'($urandom));
  endtask

  task automatic build_file();
    int csz, msz, psz, usz, nsnd, frm;
    file_q.delete();
    frm = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4000);
    put_id(dsdop_pkg::ID_FRM8); put_be(64'(frm), 8); put_id(dsdop_pkg::ID_DSD);
    put_id(dsdop_pkg::ID_FVER); put_be(64'd4, 8);
    put_be(64'({dsdop_pkg::VER_ONE, 24'($urandom)}), 4);
    psz = 4 + $urandom_range(3);
    put_id(dsdop_pkg::ID_PROP); put_be(64'(psz), 8); put_id(dsdop_pkg::TYPE_SND);
    put_id(dsdop_pkg::ID_FS); put_be(64'd4, 8); put_be(64'(cur_rate), 4);
    if (frm == 0 && $urandom_range(1)) begin
      put_id(dsdop_pkg::ID_FRM8); put_be(64'($urandom_range(1, 50)), 8);
      put_id(dsdop_pkg::ID_DSD);
    end
    csz = 6 + $urandom_range(5);
    put_id(dsdop_pkg::ID_CHNL); put_be(64'(csz), 8); put_be(64'd2, 2);
    put_fill(csz - 2, csz[0]);
    msz = 5 + $urandom_range(6);
    put_id(dsdop_pkg::ID_CMPR); put_be(64'(msz), 8); put_id(dsdop_pkg::ID_DSD);
    put_fill(msz - 4, msz[0]);
    if ($urandom_range(2) == 0) begin
      usz = $urandom_range(1, 9);
      put_id($urandom); put_be(64'(usz), 8); put_fill(usz, usz[0]);
    end
    for (int k = 0; k <= int'($urandom_range(3) == 0); k++) begin
      nsnd = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 40);
      put_id(dsdop_pkg::ID_DSD); put_be(64'(nsnd), 8); put_fill(nsnd, nsnd[0]);
    end
    // broken files: flip a bit somewhere, cut the file short, or replace it with random bytes
    if ($urandom_range(3) == 0)
      file_q[$urandom_range(file_q.size() - 1)] ^= 8'(1 << $urandom_range(7));
    if ($urandom_range(5) == 0)
      file_q = file_q[0 : $urandom_range(file_q.size() - 1)];
    if ($urandom_range(15) == 0) begin
      file_q.delete();
      put_fill($urandom_range(1, 30), 1'b0);
    end
  endtask

  task automatic send_file();
    build_file();
    foreach (file_q[i]) send_beat(1'b0, file_q[i]);
    send_beat(1'b1, 8'($urandom));
    files_sent++;
  endtask

  task automatic pick_config();
    logic [31:0] r;
    case ($urandom_range(3))
      0: r = 32'h0000_0000;
      1: r = 32'hffff_ffff;
      2: r = dsdop_pkg::RATE_RESET;
      default: r = $urandom;
    endcase
    cfg_write(dsdop_pkg::CFG_OUT_FORMAT, 32'($urandom_range(1, 3)));
    cfg_write(dsdop_pkg::CFG_REQUIRED_RATE, r);
  endtask

  initial begin
    int timed_out;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    tx_idle_pct = 17;
    rx_idle_pct = 56;
    beats_sent  = 0;
    files_sent  = 0;
    cur_rate    = dsdop_pkg::RATE_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty stream, format none, reset-config file, 24-bit with rate zero, format 3 with rate all ones
    send_beat(1'b1, 8'h00);
    drain();
    cfg_write(dsdop_pkg::CFG_OUT_FORMAT, 32'(dsdop_pkg::FMT_NONE));
    send_beat(1'b0, 8'hff);
    send_beat(1'b0, 8'h00);
    send_beat(1'b1, 8'hff);
    send_beat(1'b1, 8'h00);
    drain();
    cfg_write(dsdop_pkg::CFG_OUT_FORMAT, 32'(dsdop_pkg::FMT_RESET));
    send_file();
    drain();
    cfg_write(dsdop_pkg::CFG_OUT_FORMAT, 32'(dsdop_pkg::FMT_DOP24));
    cfg_write(dsdop_pkg::CFG_REQUIRED_RATE, 32'h0000_0000);
    send_file();
    drain();
    cfg_write(dsdop_pkg::CFG_OUT_FORMAT, 32'd3);
    cfg_write(dsdop_pkg::CFG_REQUIRED_RATE, 32'hffff_ffff);
    send_file();
    drain();

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 17 : (p == 1) ? 56 : 0;
      rx_idle_pct = (p == 0) ? 56 : (p == 1) ? 17 : 0;
      pick_config();
      for (int f = 0; f < 2; f++) begin
        while (beats_sent < 100 + (p * 2 + f + 1) * 170) send_file();
        // sender holds off until every result is back
        drain();
      end
    end

    timed_out = 0;
    for (int w = 0; pending != 0; w++) begin
      if (w > STALL_LIMIT) begin
        timed_out = 1;
        break;
      end
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (timed_out) begin
      $display("%0t: results still outstanding: %0d", $time, pending);
      $display("SCOREBOARD MISMATCH");
    end else begin
      $display("Covered %0d input beats in %0d files, %0d result beats checked.",
               beats_sent, files_sent, checked);
      if (fails == 0 && pending == 0)
        $display("SCOREBOARD CLEAN");
      else
        $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
